/* rtl/mar_pkg.sv */
`default_nettype none

package mar_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int NUM_REGS   = 32;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int OPCODE_W   = 4;
    localparam int IMM_W      = 16;
    localparam int SHAMT_W    = $clog2(DATA_WIDTH);
    localparam int HALF_W     = DATA_WIDTH / 2;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [REG_IDX_W-1:0]  reg_idx_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD  = 4'd0,
        OP_ADDI = 4'd1,
        OP_SUB  = 4'd2,
        OP_AND  = 4'd3,
        OP_OR   = 4'd4,
        OP_XOR  = 4'd5,
        OP_SLT  = 4'd6,
        OP_SLL  = 4'd7,
        OP_SRL  = 4'd8,
        OP_ROTR = 4'd9,
        OP_LUI  = 4'd10
    } op_t;

endpackage

`default_nettype wire

/* rtl/mar_instr_if.sv */
`default_nettype none

interface mar_instr_if;
    import mar_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [REG_IDX_W-1:0]       dest_reg;
    logic [REG_IDX_W-1:0]       src_a;
    logic [REG_IDX_W-1:0]       src_b;
    logic signed [IMM_W-1:0]    immediate;

    modport source (
        output valid, opcode, dest_reg, src_a, src_b, immediate,
        input  ready
    );

    modport sink (
        input  valid, opcode, dest_reg, src_a, src_b, immediate,
        output ready
    );

endinterface

`default_nettype wire

/* rtl/mar_result_if.sv */
`default_nettype none

interface mar_result_if;
    import mar_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REG_IDX_W-1:0]   written_reg;
    logic [DATA_WIDTH-1:0]  written_value;

    modport source (
        output valid, written_reg, written_value,
        input  ready
    );

    modport sink (
        input  valid, written_reg, written_value,
        output ready
    );

endinterface

`default_nettype wire

/* rtl/mar_ram.sv */
`default_nettype none

module mar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/mips_alu_register_file_top.sv */
`default_nettype none

// Integer execute stage with a 32 x 32-bit register file. One instruction beat is taken
// per cycle unless the result side stalls; its result beat (written register and value)
// passes the execute-stage and result registers. Sources are read from two copies of the
// register file in registered-read RAMs; the ALU result is written back as the instruction
// leaves the execute stage and forwarded to the next instruction, so dependent instructions
// issue back to back. Register zero reads as zero and is never written, but its result is
// still reported. Opcodes above lui are accepted and dropped without a result. The file
// reads as all zero after reset through per-register valid flops, with no clearing pass.

module mips_alu_register_file_top (
    input  logic         clk,
    input  logic         rst_n,
    mar_instr_if.sink    instr,
    mar_result_if.source result
);
    import mar_pkg::*;

    // execute stage
    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    reg_idx_t            s1_dest_reg;
    reg_idx_t            s1_src_a_reg;
    reg_idx_t            s1_src_b_reg;
    logic [IMM_W-1:0]    s1_imm_reg;

    logic [NUM_REGS-1:0] written_bits_reg;
    logic                a_written_reg;
    logic                b_written_reg;

    logic                fwd_en_reg;
    reg_idx_t            fwd_addr_reg;
    word_t               fwd_data_reg;

    logic                res_valid_reg;
    reg_idx_t            res_idx_reg;
    word_t               res_value_reg;

    logic                s1_advance;
    logic                s1_hold;
    logic                accept;
    logic                op_ok;
    reg_idx_t            rd_a;
    reg_idx_t            rd_b;
    word_t               ram_a_data;
    word_t               ram_b_data;
    word_t               opnd_a;
    word_t               opnd_b;
    word_t               imm_ext;
    logic [SHAMT_W-1:0]  shamt;
    logic [2*DATA_WIDTH-1:0] rot_wide;
    word_t               alu_result;
    logic                wr_en;

    assign s1_advance   = s1_valid_reg && (!res_valid_reg || result.ready);
    assign s1_hold      = s1_valid_reg && !s1_advance;
    assign instr.ready  = !s1_hold;
    assign accept       = instr.valid && instr.ready;
    assign op_ok        = instr.opcode inside {[OP_ADD:OP_LUI]};

    // a stalled instruction keeps re-reading its own sources
    assign rd_a = s1_hold ? s1_src_a_reg : instr.src_a;
    assign rd_b = s1_hold ? s1_src_b_reg : instr.src_b;

    assign wr_en = s1_advance && (s1_dest_reg != '0);

    mar_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_dest_reg),
        .wr_data (alu_result),
        .rd_addr (rd_a),
        .rd_data (ram_a_data)
    );

    mar_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_dest_reg),
        .wr_data (alu_result),
        .rd_addr (rd_b),
        .rd_data (ram_b_data)
    );

    // the write landing on the read edge is not seen by the ram, take it from the bypass
    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == s1_src_a_reg))
        begin
            opnd_a = fwd_data_reg;
        end
        else
        begin
            opnd_a = a_written_reg ? ram_a_data : '0;
        end
        if (fwd_en_reg && (fwd_addr_reg == s1_src_b_reg))
        begin
            opnd_b = fwd_data_reg;
        end
        else
        begin
            opnd_b = b_written_reg ? ram_b_data : '0;
        end
    end

    assign imm_ext  = {{(DATA_WIDTH-IMM_W){s1_imm_reg[IMM_W-1]}}, s1_imm_reg};
    assign shamt    = s1_imm_reg[SHAMT_W-1:0];
    assign rot_wide = {opnd_a, opnd_a} >> shamt;

    always_comb
    begin
        case (s1_op_reg)
            OP_ADD:  alu_result = opnd_a + opnd_b;
            OP_ADDI: alu_result = opnd_a + imm_ext;
            OP_SUB:  alu_result = opnd_a - opnd_b;
            OP_AND:  alu_result = opnd_a & opnd_b;
            OP_OR:   alu_result = opnd_a | opnd_b;
            OP_XOR:  alu_result = opnd_a ^ opnd_b;
            OP_SLT:  alu_result = {{(DATA_WIDTH-1){1'b0}},
                                   ($signed(opnd_a) < $signed(opnd_b))};
            OP_SLL:  alu_result = opnd_a << shamt;
            OP_SRL:  alu_result = opnd_a >> shamt;
            OP_ROTR: alu_result = rot_wide[DATA_WIDTH-1:0];
            OP_LUI:  alu_result = {opnd_a[HALF_W-1:0], {HALF_W{1'b0}}};
            default: alu_result = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            written_bits_reg <= '0;
            fwd_en_reg       <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (!s1_hold)
            begin
                s1_valid_reg <= accept && op_ok;
            end
            if (wr_en)
            begin
                written_bits_reg[s1_dest_reg] <= 1'b1;
            end
            fwd_en_reg <= wr_en;
            if (s1_advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= op_t'(instr.opcode);
            s1_dest_reg  <= instr.dest_reg;
            s1_src_a_reg <= instr.src_a;
            s1_src_b_reg <= instr.src_b;
            s1_imm_reg   <= instr.immediate;
        end
        a_written_reg <= written_bits_reg[rd_a];
        b_written_reg <= written_bits_reg[rd_b];
        fwd_addr_reg  <= s1_dest_reg;
        fwd_data_reg  <= alu_result;
        if (s1_advance)
        begin
            res_idx_reg   <= s1_dest_reg;
            res_value_reg <= alu_result;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.written_reg   = res_idx_reg;
    assign result.written_value = res_value_reg;

endmodule

`default_nettype wire

/* rtl/mar_checker.sv */
`default_nettype none

module mar_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            instr_valid,
    input logic                            instr_ready,
    input logic [mar_pkg::OPCODE_W-1:0]    instr_opcode,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [mar_pkg::REG_IDX_W-1:0]   result_reg,
    input logic [mar_pkg::DATA_WIDTH-1:0]  result_value
);
    import mar_pkg::*;

    // a stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_reg) && $stable(result_value))
    else $error("result beat changed while stalled");

    // the input side only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !instr_ready |-> result_valid && !result_ready)
    else $error("instr not ready without result back-pressure");

    // an accepted instruction with a valid opcode leads to a pending result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        instr_valid && instr_ready && (instr_opcode <= OP_LUI) |=> ##1 result_valid)
    else $error("no result beat after accepted instruction");

    // nothing comes out right after reset before anything went in
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid)
    else $error("result beat straight out of reset");

endmodule

bind mips_alu_register_file_top mar_checker u_mar_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_valid  (instr.valid),
    .instr_ready  (instr.ready),
    .instr_opcode (instr.opcode),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_reg   (result.written_reg),
    .result_value (result.written_value)
);

`default_nettype wire
